### sv/rtpc_pkg.sv
// ----------------------------------------------------------------------------
// rtpc_pkg
// Shared types, constants and register indexes for the touch point unit.
// ----------------------------------------------------------------------------
package rtpc_pkg;

  localparam int ADC_BITS = 12;
  localparam logic [15:0] ADC_MAX = 16'((1 << ADC_BITS) - 1);

  localparam logic [1:0] OP_X  = 2'd0;
  localparam logic [1:0] OP_Y  = 2'd1;
  localparam logic [1:0] OP_Z1 = 2'd2;
  localparam logic [1:0] OP_Z2 = 2'd3;

  localparam logic [1:0] ST_STORED = 2'd0;
  localparam logic [1:0] ST_NOISY  = 2'd1;
  localparam logic [1:0] ST_POINT  = 2'd2;

  localparam logic [2:0] REG_PLATE = 3'd0;
  localparam logic [2:0] REG_CXL   = 3'd1;
  localparam logic [2:0] REG_CXH   = 3'd2;
  localparam logic [2:0] REG_CYL   = 3'd3;
  localparam logic [2:0] REG_CYH   = 3'd4;
  localparam logic [2:0] REG_SXM   = 3'd5;
  localparam logic [2:0] REG_SYM   = 3'd6;
  localparam logic [2:0] REG_NOISE = 3'd7;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] sample_first;
    logic [11:0] sample_second;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] screen_x;
    logic [11:0] screen_y;
    logic [11:0] rotated_x;
    logic [11:0] rotated_y;
    logic [15:0] pressure;
  } out_item_t;

  // classified job handed from front to back
  typedef struct packed {
    logic        point;    // compute a full point
    logic        noisy;
    logic [11:0] z2;
    logic [11:0] z1;
    logic [11:0] xp;
    logic [11:0] yp;
  } job_t;

  typedef struct packed {
    logic [15:0] plate;
    logic [11:0] cxl;
    logic [11:0] cxh;
    logic [11:0] cyl;
    logic [11:0] cyh;
    logic [11:0] sxm;
    logic [11:0] sym;
  } cfg_t;

endpackage

### sv/rtpc_div.sv
// ----------------------------------------------------------------------------
// rtpc_div
// Restoring unsigned divider, one quotient bit per cycle, 40-bit operands.
// ----------------------------------------------------------------------------
module rtpc_div import rtpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [39:0] num,
  input  logic [39:0] den,
  output logic        done,
  output logic [39:0] quo
);

  logic [39:0] rem;
  logic [39:0] dv;
  logic [5:0]  cnt;
  logic        busy;
  logic [40:0] trial;

  assign trial = {rem[39:0], quo[39]} - {1'b0, dv};

  // shift in one numerator bit and subtract when it fits
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd40;
      quo  <= num;
      rem  <= '0;
      dv   <= den;
    end else if (busy) begin
      if (!trial[40]) begin
        rem <= trial[39:0];
        quo <= {quo[38:0], 1'b1};
      end else begin
        rem <= {rem[38:0], quo[39]};
        quo <= {quo[38:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

### sv/rtpc_front.sv
// ----------------------------------------------------------------------------
// rtpc_front
// Noise check, channel averaging and job queue toward the back end.
// ----------------------------------------------------------------------------
module rtpc_front import rtpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  input  logic [11:0] noise_limit,
  output logic        job_valid,
  input  logic        job_take,
  output job_t        job
);

  logic [11:0] x_avg, y_avg, z1_avg;
  logic [11:0] diff;
  logic [12:0] sum;
  logic [11:0] avg;
  logic        acc;
  job_t        q [2];
  logic        wp, rp;
  logic [1:0]  cnt;
  job_t        newjob;

  assign diff = (in_data.sample_first > in_data.sample_second) ?
                in_data.sample_first - in_data.sample_second :
                in_data.sample_second - in_data.sample_first;
  assign sum = {1'b0, in_data.sample_first} + {1'b0, in_data.sample_second};
  assign avg = sum[12:1];
  assign in_stall = (cnt == 2'd2);
  assign acc = in_valid && !in_stall;
  assign job_valid = (cnt != 2'd0);
  assign job = q[rp];

  // classify the beat
  always_comb begin
    newjob.noisy = diff > noise_limit;
    newjob.point = !newjob.noisy && (in_data.op == OP_Z2);
    newjob.z2 = avg;
    newjob.z1 = z1_avg;
    newjob.xp = x_avg;
    newjob.yp = y_avg;
  end

  // update channel state and push the job
  always_ff @(posedge clk) begin
    if (rst) begin
      x_avg <= '0; y_avg <= '0; z1_avg <= '0;
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (acc) begin
        q[wp] <= newjob;
        wp <= ~wp;
        if (!newjob.noisy) begin
          case (in_data.op)
            OP_X:    x_avg <= avg;
            OP_Y:    y_avg <= avg;
            OP_Z1:   z1_avg <= avg;
            default: ;
          endcase
        end
      end
      if (job_take) rp <= ~rp;
      cnt <= cnt + {1'b0, acc} - {1'b0, job_take};
    end
  end

endmodule

### sv/rtpc_back.sv
// ----------------------------------------------------------------------------
// rtpc_back
// Point sequencer: pressure and two calibration maps through one divider.
// ----------------------------------------------------------------------------
module rtpc_back import rtpc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      job_valid,
  output logic      job_take,
  input  job_t      job,
  input  cfg_t      cfg,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_PM1 = 7'b0000010, S_PM2 = 7'b0000100,
    S_PDIV = 7'b0001000, S_XDIV = 7'b0010000, S_YDIV = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t             state;
  job_t               j;
  logic [23:0]        prod;
  logic [39:0]        pnum;
  logic [39:0]        dnum, dden, quo;
  logic               dstart, ddone;
  logic [15:0]        ry;
  logic               pspecial;
  logic               use_pdiv;
  logic [15:0]        psimple, pres;
  logic signed [17:0] xs, ys, xr, yr;
  logic [17:0]        xmag, ymag, xsmag, ysmag;
  logic [29:0]        xnum, ynum;
  out_item_t          short_res;
  out_item_t          point_head;

  rtpc_div u_div (.clk(clk), .rst(rst), .start(dstart), .num(dnum), .den(dden),
                  .done(ddone), .quo(quo));

  assign ry = ADC_MAX - {4'd0, j.xp};
  assign psimple = ADC_MAX - ({4'd0, j.z2} - {4'd0, j.z1});
  assign job_take = (state == S_IDLE) && job_valid && !(out_valid && out_stall);
  assign pspecial = (j.z1 == 12'd0) && ({4'd0, j.z2} == ADC_MAX);
  assign use_pdiv = !pspecial && (cfg.plate != 16'd0) && (j.z1 != 12'd0) &&
                    (j.z2 > j.z1);
  assign pnum = prod * cfg.plate;

  // signed span helpers for the calibration map
  assign xs = $signed({6'd0, cfg.cxh}) - $signed({6'd0, cfg.cxl});
  assign ys = $signed({6'd0, cfg.cyh}) - $signed({6'd0, cfg.cyl});
  assign xr = $signed({6'd0, j.yp}) - $signed({6'd0, cfg.cxl});
  assign yr = $signed({2'd0, ry}) - $signed({6'd0, cfg.cyl});

  // magnitudes feed the unsigned divider, signs are settled afterwards
  assign xmag  = $unsigned(xr[17] ? -xr : xr);
  assign ymag  = $unsigned(yr[17] ? -yr : yr);
  assign xsmag = $unsigned(xs[17] ? -xs : xs);
  assign ysmag = $unsigned(ys[17] ? -ys : ys);
  assign xnum  = xmag * cfg.sxm;
  assign ynum  = ymag * cfg.sym;

  // build the fixed parts of the result beats
  always_comb begin
    short_res = '0;
    short_res.status = job.noisy ? ST_NOISY : ST_STORED;
    point_head = '0;
    point_head.status = ST_POINT;
    point_head.rotated_x = j.yp;
    point_head.rotated_y = ry[11:0];
  end

  function automatic logic [11:0] cmap(input logic signed [17:0] r,
                                       input logic signed [17:0] s,
                                       input logic [39:0] q,
                                       input logic [11:0] top);
    logic neg;
    logic [39:0] mag;
    begin
      neg = (r[17] != s[17]) && (r != 0);
      mag = q;
      if (s == 0 || neg) cmap = 12'd0;
      else if (mag > {28'd0, top}) cmap = top;
      else cmap = mag[11:0];
    end
  endfunction

  // run the point sequence
  always_ff @(posedge clk) begin
    dstart <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (job_take) begin
          j <= job;
          if (job.point) begin
            state <= S_PM1;
          end else begin
            out_data <= short_res;
            out_valid <= 1'b1;
          end
        end
        S_PM1: begin
          prod <= (j.z2 - j.z1) * j.xp;
          state <= S_PM2;
        end
        S_PM2: begin
          out_data <= point_head;
          if (pspecial) pres <= 16'd0;
          else if (cfg.plate == 16'd0) pres <= psimple;
          else pres <= 16'd0;
          dstart <= 1'b1;
          if (use_pdiv) begin
            dnum <= pnum;
            dden <= {28'd0, j.z1} << ADC_BITS;
            state <= S_PDIV;
          end else begin
            dnum <= {10'd0, xnum};
            dden <= {22'd0, xsmag};
            state <= S_XDIV;
          end
        end
        S_PDIV: if (ddone) begin
          pres <= (quo > 40'd65535) ? 16'd65535 : quo[15:0];
          dnum <= {10'd0, xnum};
          dden <= {22'd0, xsmag};
          dstart <= 1'b1;
          state <= S_XDIV;
        end
        S_XDIV: if (ddone) begin
          out_data.screen_x <= cmap(xr, xs, quo, cfg.sxm);
          dnum <= {10'd0, ynum};
          dden <= {22'd0, ysmag};
          dstart <= 1'b1;
          state <= S_YDIV;
        end
        S_YDIV: if (ddone) begin
          out_data.screen_y <= cmap(yr, ys, quo, cfg.sym);
          state <= S_OUT;
        end
        S_OUT: if (!(out_valid && out_stall)) begin
          out_data.pressure <= (pres == 16'hFFFF) ? 16'd0 : pres;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/resistive_touch_point_calc_unit.sv
// ----------------------------------------------------------------------------
// resistive_touch_point_calc_unit
// Touch screen pair filter, pressure and calibrated point computation.
// ----------------------------------------------------------------------------
// Channel and noisy beats give a result in the cycle after the back end takes
// them from the queue. A clean z2 beat runs the back end's shared bit-serial
// divider up to three times (pressure, screen x, screen y); the pressure
// divide is skipped when it is not needed. A two-entry queue lets the front
// keep accepting beats while a point computes, until the queue is full.
module resistive_touch_point_calc_unit import rtpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t        cfg;
  logic [11:0] noise_limit;
  logic        job_valid, job_take;
  job_t        job;

  // hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.plate <= 16'd0; cfg.cxl <= 12'd0; cfg.cxh <= 12'd4095;
      cfg.cyl <= 12'd0; cfg.cyh <= 12'd4095; cfg.sxm <= 12'd319;
      cfg.sym <= 12'd239; noise_limit <= 12'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PLATE: cfg.plate <= cfg_data;
        REG_CXL:   cfg.cxl <= cfg_data[11:0];
        REG_CXH:   cfg.cxh <= cfg_data[11:0];
        REG_CYL:   cfg.cyl <= cfg_data[11:0];
        REG_CYH:   cfg.cyh <= cfg_data[11:0];
        REG_SXM:   cfg.sxm <= cfg_data[11:0];
        REG_SYM:   cfg.sym <= cfg_data[11:0];
        REG_NOISE: noise_limit <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  rtpc_front u_front (.clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
                      .in_data(in_data), .noise_limit(noise_limit),
                      .job_valid(job_valid), .job_take(job_take), .job(job));

  rtpc_back u_back (.clk(clk), .rst(rst), .job_valid(job_valid), .job_take(job_take),
                    .job(job), .cfg(cfg), .out_valid(out_valid),
                    .out_stall(out_stall), .out_data(out_data));

endmodule

### sv/rtpc_checker.sv
// ----------------------------------------------------------------------------
// rtpc_checker
// Port-level checks on result beats.
// ----------------------------------------------------------------------------
module rtpc_checker import rtpc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status != 2'd3) else $error("bad status");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_POINT |-> out_data.pressure == 16'd0 &&
    out_data.screen_x == 12'd0) else $error("fields not cleared");

  a_ffff: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.pressure != 16'hFFFF) else $error("all-ones pressure");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("beat dropped");

endmodule

bind resistive_touch_point_calc_unit rtpc_checker u_chk (.clk(clk), .rst(rst),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));
